// ----- design/tmlc_pkg.sv -----
// Package for the translation map LFU cache: command codes and entry layout.
// No dependencies.
`timescale 1ns / 1ps
package tmlc_pkg;
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_SET    = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;
    localparam int ADDR_W  = 32;
    localparam int FREED_W = 13;
endpackage

// ----- design/translation_map_lfu_cache.sv -----
// Top level of the translation map LFU cache: sequencer around one entry RAM.
// Depends on tmlc_pkg and tmlc_ram.
//
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_cmd s_guest_address s_code_handle
//  m_      | out       | m_valid m_ready m_hit m_found_handle m_freed_count
//
// Reset runs a clearing pass over all NUM_SETS*WAYS entries (one per cycle);
// no transfer is taken until it ends. Flush runs the same pass, then returns a result.
// Lookup and set on hit or free way: set ways are read one per cycle (ST_RD, ST_CMP),
// then ST_WR updates the entry if any and ST_OUT registers the result.
// A set command on a full set adds aging passes, each two sweeps of the table (min
// search, subtract) and a rescan of the set.
// Result register holds while m_ready is low; input is stalled until it drains.
`timescale 1ns / 1ps
module translation_map_lfu_cache #(
    parameter int NUM_SETS   = 1024,
    parameter int WAYS       = 4,
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [31:0] s_guest_address,
    input  logic [31:0] s_code_handle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [31:0] m_found_handle,
    output logic [12:0] m_freed_count
);
    import tmlc_pkg::*;

    localparam int TOTAL = NUM_SETS * WAYS;
    localparam int IW    = $clog2(TOTAL);
    localparam int SW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int EW    = 1 + 32 + COUNT_BITS + 32;
    localparam int NW    = $clog2(WAYS + 1);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_CMP   = 4'd3;
    localparam logic [3:0] ST_WR    = 4'd4;
    localparam logic [3:0] ST_MIN   = 4'd5;
    localparam logic [3:0] ST_SUB   = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;

    typedef struct packed {
        logic                  valid;
        logic [31:0]           tag;
        logic [COUNT_BITS-1:0] cnt;
        logic [31:0]           handle;
    } entry_t;

    logic [3:0]            state_reg, state_next;
    logic [1:0]            cmd_reg;
    logic [31:0]           addr_reg, handle_reg;
    logic [IW:0]           idx_reg, idx_next;
    logic [NW-1:0]         way_reg, way_next;
    logic                  match_reg, match_next;
    logic                  free_reg, free_next;
    logic [WW-1:0]         mway_reg, mway_next, fway_reg, fway_next;
    entry_t                mentry_reg, mentry_next;
    logic [COUNT_BITS:0]   least_reg, least_next;
    logic                  rd_pend_reg;
    logic [IW-1:0]         rd_idx_reg;
    logic [FREED_W-1:0]    freed_reg, freed_next;
    logic                  out_v_reg;
    logic                  hit_reg;
    logic [31:0]           fh_reg;

    logic                  we;
    logic [IW-1:0]         waddr, raddr;
    entry_t                wdata, rdata;
    logic [IW-1:0]         base;
    logic [SW-1:0]         set_idx;

    tmlc_ram #(.WIDTH(EW), .DEPTH(TOTAL)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign set_idx = SW'(addr_reg % NUM_SETS);
    assign base    = IW'(set_idx) * IW'(WAYS);

    assign s_ready        = (state_reg == ST_IDLE) && !out_v_reg;
    assign m_valid        = out_v_reg;
    assign m_hit          = hit_reg;
    assign m_found_handle = fh_reg;
    assign m_freed_count  = freed_reg;

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        way_next    = way_reg;
        match_next  = match_reg;
        free_next   = free_reg;
        mway_next   = mway_reg;
        fway_next   = fway_reg;
        mentry_next = mentry_reg;
        least_next  = least_reg;
        freed_next  = freed_reg;
        we          = 1'b0;
        waddr       = rd_idx_reg;
        wdata       = rdata;
        raddr       = base + IW'(way_reg);
        unique case (state_reg)
            ST_CLEAR: begin
                we    = 1'b1;
                waddr = idx_reg[IW-1:0];
                wdata = '0;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (IW+1)'(TOTAL - 1)) begin
                    state_next = (cmd_reg == CMD_FLUSH) ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                way_next   = '0;
                match_next = 1'b0;
                free_next  = 1'b0;
                idx_next   = '0;
                if (s_valid && s_ready) begin
                    freed_next = '0;
                    if (s_cmd == CMD_LOOKUP || s_cmd == CMD_SET) begin
                        state_next = ST_RD;
                    end else if (s_cmd == CMD_FLUSH) begin
                        state_next = ST_CLEAR;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_RD: begin
                way_next   = way_reg + 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // rdata holds way (way_reg-1)
                if (!match_reg && rdata.valid && rdata.tag == addr_reg) begin
                    match_next  = 1'b1;
                    mway_next   = WW'(way_reg - 1'b1);
                    mentry_next = rdata;
                end
                if (!free_reg && !rdata.valid) begin
                    free_next = 1'b1;
                    fway_next = WW'(way_reg - 1'b1);
                end
                if (way_reg == NW'(WAYS)) begin
                    state_next = ST_WR;
                end else begin
                    way_next = way_reg + 1'b1;
                end
            end
            ST_WR: begin
                if (cmd_reg == CMD_LOOKUP) begin
                    if (match_reg) begin
                        we    = 1'b1;
                        waddr = base + IW'(mway_reg);
                        wdata = mentry_reg;
                        if (~&mentry_reg.cnt) begin
                            wdata.cnt = mentry_reg.cnt + 1'b1;
                        end
                    end
                    state_next = ST_OUT;
                end else if (match_reg || free_reg) begin
                    we           = 1'b1;
                    waddr        = base + IW'(match_reg ? mway_reg : fway_reg);
                    wdata.valid  = 1'b1;
                    wdata.tag    = addr_reg;
                    wdata.cnt    = COUNT_BITS'(1);
                    wdata.handle = handle_reg;
                    state_next   = ST_OUT;
                end else begin
                    idx_next   = '0;
                    least_next = '1;
                    state_next = ST_MIN;
                end
            end
            ST_MIN: begin
                raddr = idx_reg[IW-1:0];
                if (rd_pend_reg && rdata.valid
                    && {1'b0, rdata.cnt} < least_reg) begin
                    least_next = {1'b0, rdata.cnt};
                end
                if (idx_reg == (IW+1)'(TOTAL)) begin
                    if (!rd_pend_reg) begin
                        idx_next   = '0;
                        state_next = ST_SUB;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SUB: begin
                raddr = idx_reg[IW-1:0];
                if (rd_pend_reg && rdata.valid) begin
                    we        = 1'b1;
                    wdata.cnt = rdata.cnt - least_reg[COUNT_BITS-1:0];
                    if (rdata.cnt == least_reg[COUNT_BITS-1:0]) begin
                        wdata.valid = 1'b0;
                        freed_next  = freed_reg + 1'b1;
                    end
                end
                if (idx_reg == (IW+1)'(TOTAL)) begin
                    if (!rd_pend_reg) begin
                        way_next   = '0;
                        match_next = 1'b0;
                        free_next  = 1'b0;
                        state_next = ST_RD;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_OUT: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            out_v_reg   <= 1'b0;
            rd_pend_reg <= 1'b0;
            cmd_reg     <= CMD_LOOKUP;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= (state_reg == ST_MIN || state_reg == ST_SUB)
                           && idx_reg != (IW+1)'(TOTAL);
            if (s_valid && s_ready) begin
                cmd_reg <= s_cmd;
            end
            if (m_valid && m_ready) begin
                out_v_reg <= 1'b0;
            end else if (state_reg == ST_OUT) begin
                out_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        way_reg    <= way_next;
        match_reg  <= match_next;
        free_reg   <= free_next;
        mway_reg   <= mway_next;
        fway_reg   <= fway_next;
        mentry_reg <= mentry_next;
        least_reg  <= least_next;
        freed_reg  <= freed_next;
        rd_idx_reg <= raddr;
        if (s_valid && s_ready) begin
            addr_reg   <= s_guest_address;
            handle_reg <= s_code_handle;
        end
        if (state_reg == ST_OUT) begin
            hit_reg <= (cmd_reg == CMD_LOOKUP || cmd_reg == CMD_SET) && match_reg;
            fh_reg  <= (cmd_reg == CMD_LOOKUP && match_reg) ? mentry_reg.handle : 32'd0;
        end
    end

    a_freed_set: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT && cmd_reg != CMD_SET |-> freed_reg == '0);
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found_handle));
    a_no_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready);
endmodule

// ----- design/tmlc_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tmlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
